// ===== design/gradient_nonmax_suppression_unit_defines.svh =====
// assertion macros for the gradient non-maximum suppression unit
`ifndef GRADIENT_NONMAX_SUPPRESSION_UNIT_DEFINES_SVH
`define GRADIENT_NONMAX_SUPPRESSION_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GNMS_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GNMS_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/gnms_pkg.sv =====
package gnms_pkg;

	localparam int unsigned MAX_WIDTH = 1024;
	localparam int unsigned ADDR_W    = $clog2(MAX_WIDTH);
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned MAG_W     = 17;
	localparam int unsigned WIDTH_W   = 11;
	localparam int unsigned HEIGHT_W  = 13;
	localparam int unsigned CFG_W     = 13;

	localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
	localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 13'd3;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 13'd4096;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

	// tan(22.5 deg) in unsigned q0.16
	localparam logic [14:0] TAN_Q16 = 15'd27146;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [MAG_W-1:0]  mag_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {DIR_0, DIR_45, DIR_90, DIR_135} dir_t;
	typedef enum logic {REG_WIDTH, REG_HEIGHT} reg_idx_t;

	typedef struct packed {
		pix_t pixel;
		logic flush;
	} px_word_t;

	typedef struct packed {
		mag_t        magnitude_sq;
		logic [1:0]  direction;
		logic        last_of_frame;
	} res_word_t;

	// per-word raster position flags
	typedef struct packed {
		addr_t addr;
		logic  interior;
		logic  emit;
		logic  last;
		logic  i_ok;
		logic  j_ok;
	} pos_t;

	typedef struct packed {
		pos_t pos;
		pix_t pix;
	} s1_t;

	// one column of the line memory
	typedef struct packed {
		pix_t pix;
		mag_t mag_near;
		mag_t mag_far;
		dir_t dir;
	} line_word_t;

	typedef struct packed {
		pos_t pos;
		pix_t pix;
		mag_t mag_new;
		dir_t dir_new;
		mag_t mag_near;
		mag_t mag_far;
		dir_t dir_old;
	} s2_t;

	function automatic pix_t mag_abs(input logic signed [PIX_W:0] v);
		pix_t r;
		r = v[PIX_W] ? PIX_W'(-v) : v[PIX_W-1:0];
		return r;
	endfunction

	// bin of atan2(-gx, gy) folded to [0,180)
	function automatic dir_t bin_direction(input logic signed [PIX_W:0] gx,
			input logic signed [PIX_W:0] gy);
		pix_t        ax;
		pix_t        ay;
		logic [23:0] lhs_lo;
		logic [23:0] rhs_lo;
		logic [23:0] lhs_hi;
		logic [23:0] rhs_hi;
		logic        below_lo;
		logic        below_hi;
		logic        same_sign;
		dir_t        d;
		ax        = mag_abs(gx);
		ay        = mag_abs(gy);
		lhs_lo    = {ax, 16'h0000};
		rhs_lo    = 24'(TAN_Q16) * 24'(ay);
		lhs_hi    = 24'(TAN_Q16) * 24'(ax);
		rhs_hi    = {ay, 16'h0000};
		below_lo  = lhs_lo < rhs_lo;
		below_hi  = lhs_hi < rhs_hi;
		same_sign = gx[PIX_W] != gy[PIX_W];
		priority if (gx == '0) begin
			d = DIR_0;
		end else if (gy == '0) begin
			d = DIR_90;
		end else if (below_lo) begin
			d = DIR_0;
		end else if (below_hi) begin
			d = same_sign ? DIR_45 : DIR_135;
		end else begin
			d = DIR_90;
		end
		return d;
	endfunction

endpackage

// ===== design/gradient_nonmax_suppression_unit.sv =====
// channel  dir  handshake             word
// cfg      in   cfg_we                cfg_index, cfg_data
// px       in   px_valid / px_ready   px_data: pixel, flush
// res      out  res_valid / res_ready res_data: magnitude_sq, direction, last_of_frame
//
// one word per cycle unless stalled; four register stages from accept to res_valid
// (line memory read, gradient, window, output register)
// the line memory does one read and one write per cycle, one column per word
// the result for raster word n appears with word n + 2*width + 1
// px_ready drops at each frame start, until column 0 is written back
// reset clears counters, valid bits and window; line memory has no reset
// res_ready low holds the stages; px_ready falls once every stage holds a word
`include "gradient_nonmax_suppression_unit_defines.svh"

module gradient_nonmax_suppression_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  gnms_pkg::reg_idx_t          cfg_index,
	input  logic [gnms_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        px_valid,
	output logic                        px_ready,
	input  gnms_pkg::px_word_t          px_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output gnms_pkg::res_word_t         res_data
);
	import gnms_pkg::*;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	addr_t               col_q;
	logic [HEIGHT_W-1:0] row_q;

	logic [WIDTH_W-1:0]  wr_width;
	logic [HEIGHT_W-1:0] wr_height;
	logic [WIDTH_W-1:0]  col_ext;
	logic [WIDTH_W-1:0]  col_inc;
	logic [WIDTH_W-1:0]  w_m2;
	logic [HEIGHT_W-1:0] h_m1;
	logic [HEIGHT_W-1:0] h_p1;
	logic [HEIGHT_W-1:0] h_p2;
	logic                c_nz;
	logic                wrap_col;
	pos_t                pos_now;

	logic       accept;
	logic       hazard;
	logic       adv1;
	logic       adv2;
	logic       adv3;
	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	s1_t        item_s1;
	s2_t        item_s2;
	line_word_t rd_word;
	line_word_t wr_word;
	logic       mem_we;
	res_word_t  res_comb;
	logic       emit_s3;
	logic       res_valid_q;
	res_word_t  res_q;

	// clamp register writes to the supported frame size
	always_comb begin
		priority if (cfg_data[WIDTH_W-1:0] < WIDTH_MIN) begin
			wr_width = WIDTH_MIN;
		end else if (cfg_data[WIDTH_W-1:0] > WIDTH_MAX) begin
			wr_width = WIDTH_MAX;
		end else begin
			wr_width = cfg_data[WIDTH_W-1:0];
		end
		priority if (cfg_data[HEIGHT_W-1:0] < HEIGHT_MIN) begin
			wr_height = HEIGHT_MIN;
		end else if (cfg_data[HEIGHT_W-1:0] > HEIGHT_MAX) begin
			wr_height = HEIGHT_MAX;
		end else begin
			wr_height = cfg_data[HEIGHT_W-1:0];
		end
	end

	// raster position of the incoming word
	assign col_ext  = WIDTH_W'(col_q);
	assign col_inc  = col_ext + WIDTH_W'(1);
	assign wrap_col = col_inc == width_q;
	assign w_m2     = width_q - WIDTH_W'(2);
	assign h_m1     = height_q - HEIGHT_W'(1);
	assign h_p1     = height_q + HEIGHT_W'(1);
	assign h_p2     = height_q + HEIGHT_W'(2);
	assign c_nz     = col_q != '0;

	assign pos_now.addr     = col_q;
	assign pos_now.interior = (row_q >= HEIGHT_W'(2)) && (row_q <= h_m1) && c_nz
		&& (col_ext <= w_m2);
	assign pos_now.emit     = ((row_q >= HEIGHT_W'(2)) && c_nz) || (row_q >= HEIGHT_W'(3));
	assign pos_now.last     = (row_q == h_p2) && !c_nz;
	assign pos_now.i_ok     = c_nz ? ((row_q >= HEIGHT_W'(3)) && (row_q <= height_q))
		: ((row_q >= HEIGHT_W'(4)) && (row_q <= h_p1));
	assign pos_now.j_ok     = col_q >= ADDR_W'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= wr_width;
				REG_HEIGHT: height_q <= wr_height;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			priority if (pos_now.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap_col) begin
				col_q <= '0;
				row_q <= row_q + HEIGHT_W'(1);
			end else begin
				col_q <= col_inc[ADDR_W-1:0];
			end
		end
	end

	// stage handshakes
	assign adv3     = !res_valid_q || res_ready;
	assign adv2     = !valid_s3 || adv3;
	assign adv1     = !valid_s2 || adv2;
	assign hazard   = (valid_s1 && (item_s1.pos.addr == col_q))
		|| (valid_s2 && (item_s2.pos.addr == col_q));
	assign px_ready = (!valid_s1 || adv1) && !hazard;
	assign accept   = px_valid && px_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!valid_s1 || adv1) begin
				valid_s1 <= accept;
			end
			if (adv1) begin
				valid_s2 <= valid_s1;
			end
			if (adv2) begin
				valid_s3 <= valid_s2;
			end
			if (adv3) begin
				res_valid_q <= valid_s3 && emit_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.pos <= pos_now;
			item_s1.pix <= px_data.flush ? '0 : px_data.pixel;
		end
		if (adv3) begin
			res_q <= res_comb;
		end
	end

	// write back: new magnitude moves the older one into the far slot
	assign mem_we           = valid_s2 && adv2;
	assign wr_word.pix      = item_s2.pix;
	assign wr_word.mag_near = item_s2.mag_new;
	assign wr_word.mag_far  = item_s2.mag_near;
	assign wr_word.dir      = item_s2.dir_new;

	gnms_line_mem u_line_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (item_s2.pos.addr),
		.wdata (wr_word),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_word)
	);

	gnms_gradient u_gradient (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (valid_s1 && adv1),
		.s1     (item_s1),
		.rd     (rd_word),
		.s2     (item_s2)
	);

	gnms_suppress u_suppress (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (valid_s2 && adv2),
		.s2     (item_s2),
		.res    (res_comb),
		.emit   (emit_s3)
	);

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	`GNMS_CHECK(a_no_rw_collision, mem_we && accept, item_s2.pos.addr != col_q, "read of a column under write-back")
	`GNMS_CHECK_NEXT(a_frame_restart, accept && pos_now.last, (col_q == '0) && (row_q == '0), "frame position did not restart")
	`GNMS_CHECK(a_col_in_row, 1'b1, col_ext < width_q, "column counter beyond row width")
	`GNMS_CHECK(a_row_bound, 1'b1, row_q <= h_p2, "row counter beyond frame drain")

endmodule

// ===== design/gnms_line_mem.sv =====
module gnms_line_mem (
	input  logic                   clk,
	input  logic                   we,
	input  gnms_pkg::addr_t        waddr,
	input  gnms_pkg::line_word_t   wdata,
	input  logic                   re,
	input  gnms_pkg::addr_t        raddr,
	output gnms_pkg::line_word_t   rdata
);
	import gnms_pkg::*;

	line_word_t mem_q [MAX_WIDTH];
	line_word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/gnms_gradient.sv =====
module gnms_gradient (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  gnms_pkg::s1_t        s1,
	input  gnms_pkg::line_word_t rd,
	output gnms_pkg::s2_t        s2
);
	import gnms_pkg::*;

	logic signed [PIX_W:0] diff_x;
	logic signed [PIX_W:0] diff_y;
	logic signed [PIX_W:0] gx_s2;
	logic signed [PIX_W:0] gy_s2;
	pos_t                  pos_s2;
	pix_t                  pix_s2;
	mag_t                  near_s2;
	mag_t                  far_s2;
	dir_t                  dir_s2;
	pix_t                  prev_q;
	pix_t                  ax;
	pix_t                  ay;
	logic [2*PIX_W-1:0]    sq_x;
	logic [2*PIX_W-1:0]    sq_y;

	// border pixels get zero gradient
	assign diff_x = s1.pos.interior ?
		($signed({1'b0, rd.pix}) - $signed({1'b0, prev_q})) : '0;
	assign diff_y = s1.pos.interior ?
		($signed({1'b0, s1.pix}) - $signed({1'b0, rd.pix})) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (load) begin
			prev_q <= rd.pix;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			gx_s2   <= diff_x;
			gy_s2   <= diff_y;
			pos_s2  <= s1.pos;
			pix_s2  <= s1.pix;
			near_s2 <= rd.mag_near;
			far_s2  <= rd.mag_far;
			dir_s2  <= rd.dir;
		end
	end

	assign ax   = mag_abs(gx_s2);
	assign ay   = mag_abs(gy_s2);
	assign sq_x = (2*PIX_W)'(ax) * (2*PIX_W)'(ax);
	assign sq_y = (2*PIX_W)'(ay) * (2*PIX_W)'(ay);

	assign s2.pos      = pos_s2;
	assign s2.pix      = pix_s2;
	assign s2.mag_new  = MAG_W'(sq_x) + MAG_W'(sq_y);
	assign s2.dir_new  = bin_direction(gx_s2, gy_s2);
	assign s2.mag_near = near_s2;
	assign s2.mag_far  = far_s2;
	assign s2.dir_old  = dir_s2;

endmodule

// ===== design/gnms_suppress.sv =====
module gnms_suppress (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  gnms_pkg::s2_t       s2,
	output gnms_pkg::res_word_t res,
	output logic                emit
);
	import gnms_pkg::*;

	mag_t win_q [3][3];
	dir_t dirw_q [3];
	logic emit_s3;
	logic last_s3;
	logic i_ok_s3;
	logic j_ok_s3;
	mag_t centre;
	mag_t side_a;
	mag_t side_b;
	mag_t cmp;
	logic use_cmp;

	// 3x3 magnitude window, rows oldest to newest, columns left to right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[k][j] <= '0;
				end
				dirw_q[k] <= DIR_0;
			end
		end else if (load) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= s2.mag_far;
			win_q[1][2] <= s2.mag_near;
			win_q[2][2] <= s2.mag_new;
			dirw_q[0]   <= dirw_q[1];
			dirw_q[1]   <= dirw_q[2];
			dirw_q[2]   <= s2.dir_old;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			emit_s3 <= s2.pos.emit;
			last_s3 <= s2.pos.last;
			i_ok_s3 <= s2.pos.i_ok;
			j_ok_s3 <= s2.pos.j_ok;
		end
	end

	always_comb begin
		centre = win_q[1][1];
		unique case (dirw_q[1])
			DIR_0: begin
				use_cmp = i_ok_s3;
				side_a  = win_q[0][1];
				side_b  = win_q[2][1];
			end
			DIR_45: begin
				use_cmp = i_ok_s3 && j_ok_s3;
				side_a  = win_q[2][0];
				side_b  = win_q[0][2];
			end
			DIR_90: begin
				use_cmp = j_ok_s3;
				side_a  = win_q[1][0];
				side_b  = win_q[1][2];
			end
			DIR_135: begin
				use_cmp = i_ok_s3 && j_ok_s3;
				side_a  = win_q[0][0];
				side_b  = win_q[2][2];
			end
		endcase
		cmp = (side_a > side_b) ? side_a : side_b;
		res.magnitude_sq  = (use_cmp && (centre < cmp)) ? '0 : centre;
		res.direction     = dirw_q[1];
		res.last_of_frame = last_s3;
	end

	assign emit = emit_s3;

endmodule

// ===== bench/gradient_nonmax_suppression_unit_test.sv =====
`timescale 1ns / 100ps

module gradient_nonmax_suppression_unit_test;
	import gnms_pkg::*;

	localparam int unsigned LONG_HOLD     = 300;
	localparam int unsigned STALL_LIMIT   = 3000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned RANDOM_WORDS  = 100;
	localparam int unsigned MAX_SHOWN     = 40;
	localparam longint      TAN_22_5_Q16  = 27146;
	localparam longint      ONE_Q16       = 65536;

	typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_FLAT} texture_t;

	// small frame whose interior pixels fall in all four direction bins
	localparam pix_t PROBE_FRAME [16] = '{
		8'd0, 8'd0,   8'd0,   8'd0,
		8'd0, 8'd255, 8'd255, 8'd0,
		8'd0, 8'd128, 8'd0,   8'd255,
		8'd0, 8'd255, 8'd255, 8'd0
	};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	reg_idx_t         cfg_index = REG_WIDTH;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             px_valid  = 1'b0;
	logic             px_ready;
	px_word_t         px_data   = '0;
	logic             res_valid;
	logic             res_ready = 1'b0;
	res_word_t        res_data;

	gradient_nonmax_suppression_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.px_valid  (px_valid),
		.px_ready  (px_ready),
		.px_data   (px_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// raster state of the expected edge pipeline
	logic [WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
	logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
	int unsigned         row_pos    = 0;
	int unsigned         col_pos    = 0;
	pix_t                prev_pix   = '0;
	pix_t                line_pix [MAX_WIDTH];
	mag_t                mag_line [2*MAX_WIDTH];
	dir_t                dir_line [MAX_WIDTH];
	mag_t                mag_win [3][3];
	dir_t                dir_win [3];
	res_word_t           expected_edge_pixels [$];
	res_word_t           oldest_edge;

	px_word_t    pixel_backlog [$];
	int unsigned words_queued   = 0;
	int unsigned words_accepted = 0;
	int unsigned results_seen   = 0;
	int unsigned mismatches     = 0;
	bit          sender_idles   = 1'b1;
	bit          receiver_idles = 1'b1;
	bit          hold_request   = 1'b0;
	bit          hold_done      = 1'b0;
	int unsigned px_gap         = 0;
	int unsigned rx_gap         = 0;
	int unsigned rx_hold        = 0;
	int unsigned quiet_cycles   = 0;
	logic        px_taken       = 1'b0;
	logic        res_taken      = 1'b0;
	logic        px_offer;

	function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned lo,
			input int unsigned hi);
		return raw < lo ? lo : (raw > hi ? hi : raw);
	endfunction

	function automatic mag_t larger(input mag_t a, input mag_t b);
		return a > b ? a : b;
	endfunction

	// bin of atan2(-gx, gy) folded to [0,180)
	function automatic dir_t gradient_bin(input int gx, input int gy);
		longint ua;
		longint ub;
		bit     below_lo;
		bit     below_hi;
		if (gx == 0) begin
			return DIR_0;
		end
		if (gy == 0) begin
			return DIR_90;
		end
		ua       = gx < 0 ? -gx : gx;
		ub       = gy < 0 ? -gy : gy;
		below_lo = ua * ONE_Q16 < TAN_22_5_Q16 * ub;
		below_hi = TAN_22_5_Q16 * ua < ONE_Q16 * ub;
		if (below_lo) begin
			return DIR_0;
		end
		if (!below_hi) begin
			return DIR_90;
		end
		return ((-gx > 0) == (gy > 0)) ? DIR_45 : DIR_135;
	endfunction

	task automatic advance_raster(input px_word_t word);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned ro;
		int unsigned co;
		int          gx;
		int          gy;
		int          new_level;
		int          old_level;
		mag_t        m_new;
		mag_t        m_near;
		mag_t        m_far;
		mag_t        m;
		mag_t        cmp;
		dir_t        d_new;
		dir_t        d;
		bit          interior;
		bit          valid;
		bit          last;
		bit          i_ok;
		bit          j_ok;
		bit          apply;
		res_word_t   res;
		w = clamp_size(width_reg, WIDTH_MIN, WIDTH_MAX);
		h = clamp_size(height_reg, HEIGHT_MIN, HEIGHT_MAX);
		r = row_pos;
		c = col_pos;
		if (c >= w) begin
			c = 0;
		end
		new_level = word.flush ? 0 : int'(word.pixel);
		old_level = int'(line_pix[c]);
		gx        = 0;
		gy        = 0;
		interior  = r >= 2 && r - 1 <= h - 2 && c >= 1 && c <= w - 2;
		if (interior) begin
			gx = old_level - int'(prev_pix);
			gy = new_level - old_level;
		end
		prev_pix    = pix_t'(old_level);
		line_pix[c] = pix_t'(new_level);
		m_new       = mag_t'(gx * gx + gy * gy);
		d_new       = gradient_bin(gx, gy);

		m_near                  = mag_line[c];
		m_far                   = mag_line[MAX_WIDTH + c];
		mag_line[MAX_WIDTH + c] = m_near;
		mag_line[c]             = m_new;
		for (int k = 0; k < 3; k++) begin
			mag_win[k][0] = mag_win[k][1];
			mag_win[k][1] = mag_win[k][2];
		end
		mag_win[0][2] = m_far;
		mag_win[1][2] = m_near;
		mag_win[2][2] = m_new;
		dir_win[0]    = dir_win[1];
		dir_win[1]    = dir_win[2];
		dir_win[2]    = dir_line[c];
		dir_line[c]   = d_new;

		valid = (r >= 2 && c >= 1) || r >= 3;
		if (c >= 1) begin
			ro = r - 2;
			co = c - 1;
		end else begin
			ro = r - 3;
			co = w - 1;
		end
		last = r == h + 2 && c == 0;
		if (last) begin
			row_pos = 0;
			col_pos = 0;
		end else begin
			c++;
			if (c >= w) begin
				c = 0;
				r++;
			end
			row_pos = r;
			col_pos = c;
		end

		if (valid) begin
			i_ok = ro >= 1 && ro <= h - 2;
			j_ok = co >= 1 && co <= w - 2;
			m    = mag_win[1][1];
			d    = dir_win[1];
			case (d)
			DIR_0: begin
				apply = i_ok;
				cmp   = larger(mag_win[0][1], mag_win[2][1]);
			end
			DIR_45: begin
				apply = i_ok && j_ok;
				cmp   = larger(mag_win[2][0], mag_win[0][2]);
			end
			DIR_90: begin
				apply = j_ok;
				cmp   = larger(mag_win[1][0], mag_win[1][2]);
			end
			default: begin
				apply = i_ok && j_ok;
				cmp   = larger(mag_win[0][0], mag_win[2][2]);
			end
			endcase
			if (apply && m < cmp) begin
				m = '0;
			end
			res.magnitude_sq  = m;
			res.direction     = d;
			res.last_of_frame = last;
			expected_edge_pixels.push_back(res);
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_SHOWN) begin
			$display("%0t mismatch: %0s", $time, msg);
		end
	endtask

	function automatic pix_t draw_level(input texture_t texture, input pix_t base);
		case (texture)
		TEXTURE_NOISE:  return pix_t'($urandom_range(0, 255));
		TEXTURE_BINARY: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
		default:        return base + pix_t'($urandom_range(0, 3));
		endcase
	endfunction

	task automatic queue_word(input logic flush, input pix_t level);
		px_word_t word;
		word.pixel = level;
		word.flush = flush;
		pixel_backlog.push_back(word);
		words_queued++;
	endtask

	// raster pixels first, drain words after the last one
	task automatic queue_frame(input int unsigned w, input int unsigned h,
			input texture_t texture, input int unsigned count);
		pix_t base;
		base = pix_t'($urandom_range(0, 252));
		for (int unsigned n = 0; n < count; n++) begin
			if (n < w * h) begin
				queue_word($urandom_range(0, 11) == 0, draw_level(texture, base));
			end else begin
				queue_word(1'($urandom_range(0, 1)), pix_t'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic write_size(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_for_idle();
		while (words_accepted != words_queued || expected_edge_pixels.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// pixel driver
	always @(negedge clk) begin
		if (arst_n) begin
			px_offer = px_valid && !px_taken;
			if (px_taken) begin
				px_gap = sender_idles && $urandom_range(0, 1) ? $urandom_range(0, 18) : 0;
			end
			if (!px_offer) begin
				if (px_gap != 0) begin
					px_gap--;
				end else if (pixel_backlog.size() != 0) begin
					px_data  <= pixel_backlog.pop_front();
					px_offer = 1'b1;
				end
			end
			px_valid <= px_offer;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken) begin
				rx_gap = receiver_idles && $urandom_range(0, 1) ? $urandom_range(0, 18) : 0;
			end
			if (hold_request && !hold_done) begin
				rx_hold   = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (rx_hold != 0) begin
				rx_hold--;
				res_ready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		px_taken  <= px_valid && px_ready;
		res_taken <= res_valid && res_ready;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH) begin
					width_reg = cfg_data[WIDTH_W-1:0];
				end else begin
					height_reg = cfg_data[HEIGHT_W-1:0];
				end
				row_pos = 0;
				col_pos = 0;
			end
			if (px_valid && px_ready) begin
				words_accepted++;
				advance_raster(px_data);
			end
			if (res_valid && res_ready) begin
				results_seen++;
				if (expected_edge_pixels.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						results_seen));
				end else begin
					oldest_edge = expected_edge_pixels.pop_front();
					if (res_data.magnitude_sq !== oldest_edge.magnitude_sq) begin
						report_mismatch($sformatf("result %0d magnitude_sq %0d, expected %0d",
							results_seen, res_data.magnitude_sq, oldest_edge.magnitude_sq));
					end
					if (res_data.direction !== oldest_edge.direction) begin
						report_mismatch($sformatf("result %0d direction %0d, expected %0d",
							results_seen, res_data.direction, oldest_edge.direction));
					end
					if (res_data.last_of_frame !== oldest_edge.last_of_frame) begin
						report_mismatch($sformatf("result %0d last_of_frame %0b, expected %0b",
							results_seen, res_data.last_of_frame, oldest_edge.last_of_frame));
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((px_valid && px_ready) || (res_valid && res_ready) || cfg_we) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int unsigned raw_w;
		int unsigned raw_h;
		int unsigned w;
		int unsigned h;
		int unsigned frames;
		int unsigned start;
		texture_t    texture;
		foreach (line_pix[i]) begin
			line_pix[i] = '0;
			dir_line[i] = DIR_0;
		end
		foreach (mag_line[i]) begin
			mag_line[i] = '0;
		end
		foreach (mag_win[i, j]) begin
			mag_win[i][j] = '0;
		end
		foreach (dir_win[i]) begin
			dir_win[i] = DIR_0;
		end
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset sizes, frame cut short by the next write
		queue_frame(640, 480, TEXTURE_NOISE, 2 * 640 + 11);
		wait_for_idle();

		write_size(REG_WIDTH, 13'd4);
		write_size(REG_HEIGHT, 13'd4);
		for (int i = 0; i < 16; i++) begin
			queue_word(i == 14, PROBE_FRAME[i]);
		end
		for (int i = 0; i < 9; i++) begin
			queue_word(i[0], i[1] ? 8'd255 : 8'd0);
		end
		wait_for_idle();

		// sizes below the minimum, unused upper width bits set
		write_size(REG_WIDTH, 13'h1800);
		write_size(REG_HEIGHT, 13'd2);
		queue_frame(3, 3, TEXTURE_BINARY, 3 * 3 + 2 * 3 + 1);
		wait_for_idle();

		start = words_queued;
		while (words_queued - start < RANDOM_WORDS) begin
			if ($urandom_range(0, 7) == 0) begin
				raw_w = $urandom_range(0, 2);
			end else begin
				raw_w = $urandom_range(3, 16);
			end
			if ($urandom_range(0, 7) == 0) begin
				raw_h = $urandom_range(0, 2);
			end else begin
				raw_h = $urandom_range(3, 12);
			end
			w = clamp_size(raw_w, WIDTH_MIN, WIDTH_MAX);
			h = clamp_size(raw_h, HEIGHT_MIN, HEIGHT_MAX);
			write_size(REG_WIDTH, CFG_W'(raw_w | ($urandom_range(0, 3) << WIDTH_W)));
			write_size(REG_HEIGHT, CFG_W'(raw_h));
			sender_idles   = $urandom_range(0, 3) != 0;
			receiver_idles = $urandom_range(0, 3) != 0;
			texture        = texture_t'($urandom_range(0, 2));
			frames         = $urandom_range(1, 3);
			for (int unsigned f = 0; f < frames; f++) begin
				queue_frame(w, h, texture, w * h + 2 * w + 1);
			end
			if ($urandom_range(0, 5) == 0) begin
				queue_frame(w, h, texture, $urandom_range(1, w * h + 2 * w));
			end
			wait_for_idle();
		end

		// receiver holds off while the sender keeps offering
		write_size(REG_WIDTH, 13'd8);
		write_size(REG_HEIGHT, 13'd10);
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		hold_request   = 1'b1;
		queue_frame(8, 10, TEXTURE_NOISE, 8 * 10 + 2 * 8 + 1);
		wait_for_idle();

		// largest sizes, each paired with the smallest size on the other axis
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		write_size(REG_WIDTH, 13'd1024);
		write_size(REG_HEIGHT, 13'd0);
		queue_frame(1024, 3, TEXTURE_NOISE, 40);
		wait_for_idle();

		write_size(REG_WIDTH, 13'd2047);
		write_size(REG_HEIGHT, 13'd3);
		queue_frame(1024, 3, TEXTURE_BINARY, 30);
		wait_for_idle();

		sender_idles = 1'b0;
		write_size(REG_WIDTH, 13'd3);
		write_size(REG_HEIGHT, 13'd8191);
		queue_frame(3, 4096, TEXTURE_NOISE, 40);
		wait_for_idle();

		sender_idles = 1'b1;
		write_size(REG_HEIGHT, 13'd4096);
		write_size(REG_WIDTH, 13'd1);
		queue_frame(3, 4096, TEXTURE_FLAT, 40);
		wait_for_idle();

		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== gradient_nonmax_suppression_unit.f =====
+incdir+design
design/gnms_pkg.sv
design/gnms_line_mem.sv
design/gnms_gradient.sv
design/gnms_suppress.sv
design/gradient_nonmax_suppression_unit.sv
bench/gradient_nonmax_suppression_unit_test.sv
